// ----- sv/tlf_pkg.sv -----
`timescale 1ns / 1ps

package tlf_pkg;

  localparam int VW = 52;
  localparam int ZW = 33;
  localparam int RW = 36;
  localparam int SW = 34;
  localparam int TW = 40;
  localparam int IDX_W = 8;
  localparam int TAB_LEN = 24;

  localparam logic [IDX_W-1:0] REG_STIFFNESS_B = 8'd0;
  localparam logic [IDX_W-1:0] REG_SHAPE_C     = 8'd1;
  localparam logic [IDX_W-1:0] REG_PEAK_D      = 8'd2;
  localparam logic [IDX_W-1:0] REG_CURVATURE_E = 8'd3;

  localparam logic [15:0] RESET_B = 16'd2560;
  localparam logic [15:0] RESET_C = 16'd6144;
  localparam logic [15:0] RESET_D = 16'd4096;
  localparam logic [15:0] RESET_E = 16'd0;

  localparam logic signed [VW-1:0] ONE_Q30     = 52'sd1073741824;
  localparam logic signed [SW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [TW-1:0] PI_Q30      = 40'sd3373259426;
  localparam logic signed [TW-1:0] HALF_PI_Q30 = 40'sd1686629713;
  localparam logic signed [TW-1:0] TWO_PI_Q30  = 40'sd6746518852;

  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255, 32'd127
  };

endpackage

// ----- sv/tlf_if.sv -----
`timescale 1ns / 1ps

interface tlf_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] slip_angle;
  logic        [15:0] normal_load;
  modport source (output valid, slip_angle, normal_load, input ready);
  modport sink (input valid, slip_angle, normal_load, output ready);
endinterface

interface tlf_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] lateral_force;
  modport source (output valid, lateral_force, input ready);
  modport sink (input valid, lateral_force, output ready);
endinterface

interface tlf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tlf_pkg::IDX_W-1:0]    index;
  logic [15:0]                  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/tlf_cordic_vec.sv -----
`timescale 1ns / 1ps

module tlf_cordic_vec #(
  parameter int STEPS  = 16,
  parameter int SIDE_W = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic signed [tlf_pkg::VW-1:0]   y_in,
  input  logic        [SIDE_W-1:0]        side_in,
  output logic                            out_valid,
  output logic signed [tlf_pkg::ZW-1:0]   z_out,
  output logic        [SIDE_W-1:0]        side_out
);

  logic signed [tlf_pkg::VW-1:0] xs [STEPS+1];
  logic signed [tlf_pkg::VW-1:0] ys [STEPS+1];
  logic signed [tlf_pkg::ZW-1:0] zs [STEPS+1];
  logic        [SIDE_W-1:0]      sd [STEPS+1];
  logic                          vs [STEPS+1];

  assign xs[0] = tlf_pkg::ONE_Q30;
  assign ys[0] = y_in;
  assign zs[0] = '0;
  assign sd[0] = side_in;
  assign vs[0] = in_valid;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [tlf_pkg::ZW-1:0] TAB = tlf_pkg::ZW'(tlf_pkg::ATAN_TAB[i]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[i+1] <= sd[i];
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + TAB;
        end else if (ys[i] < 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - TAB;
        end else begin
          xs[i+1] <= xs[i];
          ys[i+1] <= ys[i];
          zs[i+1] <= zs[i];
        end
      end
    end
  end

  assign out_valid = vs[STEPS];
  assign z_out     = zs[STEPS];
  assign side_out  = sd[STEPS];

endmodule

// ----- sv/tlf_cordic_rot.sv -----
`timescale 1ns / 1ps

module tlf_cordic_rot #(
  parameter int STEPS  = 16,
  parameter int SIDE_W = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic signed [tlf_pkg::RW-1:0]   z_in,
  input  logic        [SIDE_W-1:0]        side_in,
  output logic                            out_valid,
  output logic signed [tlf_pkg::SW-1:0]   y_out,
  output logic        [SIDE_W-1:0]        side_out
);

  logic signed [tlf_pkg::SW-1:0] xs [STEPS+1];
  logic signed [tlf_pkg::SW-1:0] ys [STEPS+1];
  logic signed [tlf_pkg::RW-1:0] zs [STEPS+1];
  logic        [SIDE_W-1:0]      sd [STEPS+1];
  logic                          vs [STEPS+1];

  assign xs[0] = tlf_pkg::GAIN_Q30;
  assign ys[0] = '0;
  assign zs[0] = z_in;
  assign sd[0] = side_in;
  assign vs[0] = in_valid;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [tlf_pkg::RW-1:0] TAB = tlf_pkg::RW'(tlf_pkg::ATAN_TAB[i]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[i+1] <= sd[i];
        if (zs[i] > 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - TAB;
        end else if (zs[i] < 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + TAB;
        end else begin
          xs[i+1] <= xs[i];
          ys[i+1] <= ys[i];
          zs[i+1] <= zs[i];
        end
      end
    end
  end

  assign out_valid = vs[STEPS];
  assign y_out     = ys[STEPS];
  assign side_out  = sd[STEPS];

endmodule

// ----- sv/tire_lateral_force.sv -----
`timescale 1ns / 1ps

// Channel  Role    Payload
// cfg      sink    index[7:0], data[15:0]
// sample   sink    slip_angle[15:0] signed, normal_load[15:0]
// result   source  lateral_force[31:0] signed
//
// One word is accepted per cycle unless result stalls; each word passes through
// the three unrolled CORDIC pipelines. Reset clears the valid bits and loads
// the register defaults. A stall on result freezes the whole pipeline, and
// sample.ready falls only while a finished word waits.

module tire_lateral_force #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst,
  tlf_cfg_if.sink       cfg,
  tlf_sample_if.sink    sample,
  tlf_result_if.source  result
);

  localparam int VW = tlf_pkg::VW;
  localparam int ZW = tlf_pkg::ZW;
  localparam int TW = tlf_pkg::TW;
  localparam int RW = tlf_pkg::RW;
  localparam int SW = tlf_pkg::SW;
  localparam int PW = SW + 33;

  logic        [15:0] stiffness_b, shape_c, peak_d;
  logic signed [15:0] curvature_e;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness_b <= tlf_pkg::RESET_B;
      shape_c     <= tlf_pkg::RESET_C;
      peak_d      <= tlf_pkg::RESET_D;
      curvature_e <= tlf_pkg::RESET_E;
    end else if (cfg.valid) begin
      case (cfg.index)
        tlf_pkg::REG_STIFFNESS_B: stiffness_b <= cfg.data;
        tlf_pkg::REG_SHAPE_C:     shape_c     <= cfg.data;
        tlf_pkg::REG_PEAK_D:      peak_d      <= cfg.data;
        tlf_pkg::REG_CURVATURE_E: curvature_e <= cfg.data;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid;
  logic signed [31:0] out_force;

  assign en = !out_valid || result.ready;
  assign sample.ready = en;

  logic               v1;
  logic signed [32:0] ba1;
  logic        [15:0] load1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ba1   <= $signed({1'b0, stiffness_b}) * sample.slip_angle;
      load1 <= sample.normal_load;
    end
  end

  logic signed [VW-1:0] y0;
  logic                 va;
  logic signed [ZW-1:0] at1;
  logic        [48:0]   side_a;

  assign y0 = {{(VW-43){ba1[32]}}, ba1, 10'b0};

  tlf_cordic_vec #(.STEPS(CORDIC_STEPS), .SIDE_W(49)) u_atan1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1), .y_in(y0),
    .side_in({ba1, load1}), .out_valid(va), .z_out(at1), .side_out(side_a)
  );

  logic               v2;
  logic signed [49:0] lin_prod;
  logic signed [48:0] cur_prod;
  logic        [15:0] load2;
  logic signed [16:0] one_minus_e;

  assign one_minus_e = 17'sd4096 - 17'(curvature_e);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin_prod <= $signed(side_a[48:16]) * one_minus_e;
      cur_prod <= curvature_e * at1;
      load2    <= side_a[15:0];
    end
  end

  logic               v3;
  logic signed [VW-1:0] u3;
  logic        [15:0] load3;
  logic signed [49:0] lin_r;
  logic signed [48:0] cur_r;

  assign lin_r = (lin_prod + 50'sd2) >>> 2;
  assign cur_r = (cur_prod + 49'sd2048) >>> 12;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u3    <= VW'(lin_r) + VW'(cur_r);
      load3 <= load2;
    end
  end

  logic                 vb;
  logic signed [ZW-1:0] at2;
  logic        [15:0]   side_b;

  tlf_cordic_vec #(.STEPS(CORDIC_STEPS), .SIDE_W(16)) u_atan2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3), .y_in(u3),
    .side_in(load3), .out_valid(vb), .z_out(at2), .side_out(side_b)
  );

  logic               v4, v5, v6, v7;
  logic signed [49:0] t_prod;
  logic signed [TW-1:0] t5, r6, r7;
  logic        [15:0] load4, load5, load6;
  logic        [31:0] dl7;
  logic signed [49:0] t_round;
  logic        [2:0]  k;
  logic signed [TW-1:0] r_fold;

  assign t_round = (t_prod + 50'sd2048) >>> 12;

  always_comb begin
    k = '0;
    for (int j = 1; j <= 5; j++) begin
      if (t5 >= 0) begin
        if (t5 >= TW'(j) * tlf_pkg::TWO_PI_Q30) k = k + 3'd1;
      end else begin
        if (t5 <= -(TW'(j) * tlf_pkg::TWO_PI_Q30)) k = k + 3'd1;
      end
    end
  end

  always_comb begin
    r_fold = r6;
    if (r_fold > tlf_pkg::PI_Q30) r_fold = r_fold - tlf_pkg::TWO_PI_Q30;
    if (r_fold < -tlf_pkg::PI_Q30) r_fold = r_fold + tlf_pkg::TWO_PI_Q30;
    if (r_fold > tlf_pkg::HALF_PI_Q30) r_fold = tlf_pkg::PI_Q30 - r_fold;
    if (r_fold < -tlf_pkg::HALF_PI_Q30) r_fold = -tlf_pkg::PI_Q30 - r_fold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v4 <= vb;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_prod <= $signed({1'b0, shape_c}) * at2;
      load4  <= side_b;
      t5     <= TW'(t_round);
      load5  <= load4;
      if (t5 >= 0) begin
        r6 <= t5 - $signed({1'b0, k}) * tlf_pkg::TWO_PI_Q30;
      end else begin
        r6 <= t5 + $signed({1'b0, k}) * tlf_pkg::TWO_PI_Q30;
      end
      load6  <= load5;
      r7     <= r_fold;
      dl7    <= peak_d * load6;
    end
  end

  logic                 vc;
  logic signed [SW-1:0] s_sin;
  logic        [31:0]   side_c;

  tlf_cordic_rot #(.STEPS(CORDIC_STEPS), .SIDE_W(32)) u_sin (
    .clk(clk), .rst(rst), .en(en), .in_valid(v7), .z_in(RW'(r7)),
    .side_in(dl7), .out_valid(vc), .y_out(s_sin), .side_out(side_c)
  );

  localparam logic signed [PW-1:0] HALF42 = PW'(1) <<< 41;

  logic               v8;
  logic signed [PW-1:0] prod8;
  logic signed [PW-1:0] f_round;
  logic signed [31:0] f_sat;

  assign f_round = (prod8 + HALF42) >>> 42;

  always_comb begin
    if (f_round > PW'(32'sh7fffffff)) begin
      f_sat = 32'sh7fffffff;
    end else if (f_round < -PW'(33'sh080000000)) begin
      f_sat = -32'sh7fffffff - 32'sd1;
    end else begin
      f_sat = f_round[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v8        <= vc;
      out_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod8     <= s_sin * $signed({1'b0, side_c});
      out_force <= f_sat;
    end
  end

  assign result.valid         = out_valid;
  assign result.lateral_force = out_force;

  a_reset_empty : assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  a_ready_rule : assert property (@(posedge clk) disable iff (rst)
    sample.ready == (!result.valid || result.ready))
    else $error("sample ready does not follow the output stage");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.lateral_force))
    else $error("stalled result word changed");

  a_range : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.lateral_force <= 32'sd2097152 &&
                      result.lateral_force >= -32'sd2097152))
    else $error("force outside the reachable range");

endmodule
